@@ src/dbchs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbchs_pkg: shared types and constants for the disk block CHS/RPS scheduler
// Field widths, action codes, register indexes and the pipeline stage word.
// ----------------------------------------------------------------------------
package dbchs_pkg;

  // Request fields
  localparam int BLK_W      = 24;
  localparam int QD_W       = BLK_W - 1;   // magnitude bits of a non-negative block
  localparam int BYTE_W     = 20;
  localparam int CYL_IN_W   = 16;
  localparam int LA_IN_W    = 16;

  // Geometry and configuration
  localparam int SPT_W      = 8;
  localparam int TPC_W      = 6;
  localparam int SPC_W      = SPT_W + TPC_W;
  localparam int PB_W       = 24;
  localparam int OFF_W      = 12;
  localparam int LEAD_W     = 6;
  localparam int MARGIN_W   = 6;
  localparam int CYLX_W     = 24;          // quotient plus offset, no overflow
  localparam int ACT_W      = 2;
  localparam int DIST_W     = 18;          // signed rotational distance

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  // Actions
  localparam logic [ACT_W-1:0] ACT_REJECT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DIRECT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEEK   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPC       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PART_BLKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYL_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_ONLY = 3'd6;

  // Reset values
  localparam logic [SPT_W-1:0]    SPT_RST       = 8'd22;
  localparam logic [TPC_W-1:0]    TPC_RST       = 6'd19;
  localparam logic [SPC_W-1:0]    SPC_RST       = 14'd418;
  localparam logic [PB_W-1:0]     PART_BLKS_RST = 24'd340670;
  localparam logic [OFF_W-1:0]    CYL_OFF_RST   = 12'd0;
  localparam logic [LEAD_W-1:0]   LEAD_RST      = 6'd2;
  localparam logic [MARGIN_W-1:0] MARGIN_RST    = 6'd3;

  // One word travelling down the pipeline
  typedef struct packed {
    logic                rej;
    logic                rdy;
    logic                skip;
    logic                rot_ok;
    logic [CYL_IN_W-1:0] cur_cyl;
    logic [QD_W-1:0]     qd;      // dividend bits in, cylinder quotient bits out
    logic [SPC_W-1:0]    prem;    // partial remainder of block / spc
    logic [CYLX_W-1:0]   cyl;
    logic [SPT_W-1:0]    trem;    // partial remainder of rem / spt
    logic [TPC_W-1:0]    tqd;     // remainder bits in, track bits out
    logic [SPT_W-1:0]    lrem;    // partial remainder of lead / spt
    logic [LEAD_W-1:0]   lqd;
  } stage_t;

  typedef struct packed {
    logic                load;
    logic [SPT_W-1:0]    ssec;
    logic [SPT_W-1:0]    sec;
    logic [TPC_W-1:0]    trk;
    logic [CYL_IN_W-1:0] cyl;
    logic [ACT_W-1:0]    action;
  } result_t;

endpackage

@@ src/disk_block_chs_rps_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_block_chs_rps_scheduler_top: block to cylinder/track/sector translator
// Pipelined restoring dividers split the block number by sectors-per-cylinder
// and then sectors-per-track, and a final stage picks the positioning action.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no output word waits untaken; the cylinder
// divider retires one quotient bit per stage (23 stages) and the track divider one
// bit per stage (6 stages).
// All stages advance together and hold while the output word is not taken.
// Reset clears the stage valid bits and the output valid, and loads the
// register defaults; there is no clearing pass.
module disk_block_chs_rps_scheduler_top #(
  parameter int BLOCK_BYTES_LOG2   = 9,
  parameter int SECTOR_FIELD_SHIFT = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // block_number[23:0], byte_count[43:24], current_cylinder[59:44],
  // lookahead_reg[75:60], drive_ready[76], skip_positioning[77], zeros[79:78]
  input  logic [dbchs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // action[1:0], target_cylinder[17:2], target_track[23:18],
  // target_sector[31:24], search_sector[39:32], load_cylinder[40], zeros[47:41]
  output logic [dbchs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [dbchs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dbchs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dbchs_pkg::*;

  localparam int ST_TINIT = QD_W + 1;
  localparam int NSTG     = ST_TINIT + TPC_W + 1;
  localparam int LAST     = NSTG - 1;
  localparam int NBLK_W   = BYTE_W + 1 - BLOCK_BYTES_LOG2;
  localparam int LA_W     = LA_IN_W - SECTOR_FIELD_SHIFT;
  localparam logic [BYTE_W:0] ROUND_ADD = (BYTE_W+1)'((1 << BLOCK_BYTES_LOG2) - 1);

  // Configuration registers
  logic [SPT_W-1:0]    spt_r;
  logic [TPC_W-1:0]    tpc_r;
  logic [SPC_W-1:0]    spc_r;
  logic [PB_W-1:0]     pb_r;
  logic [OFF_W-1:0]    cyl_off_r;
  logic [LEAD_W-1:0]   lead_r;
  logic [MARGIN_W-1:0] margin_r;
  logic                seek_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r       <= SPT_RST;
      tpc_r       <= TPC_RST;
      spc_r       <= SPC_RST;
      pb_r        <= PART_BLKS_RST;
      cyl_off_r   <= CYL_OFF_RST;
      lead_r      <= LEAD_RST;
      margin_r    <= MARGIN_RST;
      seek_only_r <= 1'b0;
    end else begin
      // The product is registered from the spt and tpc registers; it is first used by the divider stages.
      spc_r <= {{TPC_W{1'b0}}, spt_r} * {{SPT_W{1'b0}}, tpc_r};
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPT:       spt_r       <= cfg_wdata[SPT_W-1:0];
          REG_TPC:       tpc_r       <= cfg_wdata[TPC_W-1:0];
          REG_PART_BLKS: pb_r        <= cfg_wdata[PB_W-1:0];
          REG_CYL_OFF:   cyl_off_r   <= cfg_wdata[OFF_W-1:0];
          REG_LEAD:      lead_r      <= cfg_wdata[LEAD_W-1:0];
          REG_MARGIN:    margin_r    <= cfg_wdata[MARGIN_W-1:0];
          REG_SEEK_ONLY: seek_only_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Pipeline control
  logic            ce;
  logic            out_valid_r;
  logic [NSTG-1:0] vld_r;
  stage_t          stg_r   [NSTG];
  stage_t          stg_nxt [NSTG];
  result_t         out_res_r;
  result_t         res_nxt;

  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  // Stage 0: range check and rotational distance
  logic [BLK_W-1:0]           blk_w;
  logic [BYTE_W-1:0]          bytes_w;
  logic [BYTE_W:0]            rsum_w;
  logic [NBLK_W-1:0]          nblk_w;
  logic [BLK_W:0]             end_w;
  logic [LA_IN_W-1:0]         la_w;
  logic [LA_W-1:0]            la_sec_w;
  logic signed [DIST_W-1:0]   la_s, spt_s, mar_s, dist0_s, dist_s, lim_s;

  assign blk_w    = in_tdata[BLK_W-1:0];
  assign bytes_w  = in_tdata[43:24];
  assign la_w     = in_tdata[75:60];
  assign rsum_w   = {1'b0, bytes_w} + ROUND_ADD;
  assign nblk_w   = rsum_w[BYTE_W:BLOCK_BYTES_LOG2];
  assign end_w    = {1'b0, blk_w} + (BLK_W+1)'(nblk_w);
  assign la_sec_w = la_w[LA_IN_W-1:SECTOR_FIELD_SHIFT];
  assign la_s     = {{(DIST_W-LA_W){1'b0}}, la_sec_w};
  assign spt_s    = {{(DIST_W-SPT_W){1'b0}}, spt_r};
  assign mar_s    = {{(DIST_W-MARGIN_W){1'b0}}, margin_r};
  assign dist0_s  = la_s - spt_s + $signed(DIST_W'(1));
  assign dist_s   = dist0_s[DIST_W-1] ? dist0_s + spt_s : dist0_s;
  assign lim_s    = spt_s - mar_s;

  always_comb begin
    stg_nxt[0]         = '0;
    stg_nxt[0].rej     = blk_w[BLK_W-1] || (spt_r == '0) || (tpc_r == '0) ||
                         (end_w > {1'b0, pb_r});
    stg_nxt[0].rdy     = in_tdata[76];
    stg_nxt[0].skip    = in_tdata[77];
    stg_nxt[0].rot_ok  = dist_s > lim_s;
    stg_nxt[0].cur_cyl = in_tdata[59:44];
    stg_nxt[0].qd      = blk_w[QD_W-1:0];
  end

  for (genvar i = 1; i < NSTG; i++) begin : g_stage
    if (i <= QD_W) begin : g_cyl
      // One restoring step of block / sectors-per-cylinder.
      logic [SPC_W:0] shift_w;
      logic           ge_w;
      stage_t         step_nxt;
      assign shift_w = {stg_r[i-1].prem, stg_r[i-1].qd[QD_W-1]};
      assign ge_w    = shift_w >= {1'b0, spc_r};
      always_comb begin
        step_nxt    = stg_r[i-1];
        step_nxt.qd = {stg_r[i-1].qd[QD_W-2:0], ge_w};
        if (ge_w) begin
          step_nxt.prem = shift_w[SPC_W-1:0] - spc_r;
        end else begin
          step_nxt.prem = shift_w[SPC_W-1:0];
        end
      end
      assign stg_nxt[i] = step_nxt;
    end else if (i == ST_TINIT) begin : g_init
      // The track is below 64, so the top remainder bits are already below spt.
      stage_t step_nxt;
      always_comb begin
        step_nxt      = stg_r[i-1];
        step_nxt.cyl  = CYLX_W'(stg_r[i-1].qd) + CYLX_W'(cyl_off_r);
        step_nxt.trem = stg_r[i-1].prem[SPC_W-1:TPC_W];
        step_nxt.tqd  = stg_r[i-1].prem[TPC_W-1:0];
        step_nxt.lrem = '0;
        step_nxt.lqd  = lead_r;
      end
      assign stg_nxt[i] = step_nxt;
    end else begin : g_trk
      // Track and lead divisions by sectors-per-track run side by side.
      logic [SPT_W:0] tshift_w, lshift_w;
      logic           tge_w, lge_w;
      stage_t         step_nxt;
      assign tshift_w = {stg_r[i-1].trem, stg_r[i-1].tqd[TPC_W-1]};
      assign lshift_w = {stg_r[i-1].lrem, stg_r[i-1].lqd[LEAD_W-1]};
      assign tge_w    = tshift_w >= {1'b0, spt_r};
      assign lge_w    = lshift_w >= {1'b0, spt_r};
      always_comb begin
        step_nxt     = stg_r[i-1];
        step_nxt.tqd = {stg_r[i-1].tqd[TPC_W-2:0], tge_w};
        step_nxt.lqd = {stg_r[i-1].lqd[LEAD_W-2:0], lge_w};
        if (tge_w) begin
          step_nxt.trem = tshift_w[SPT_W-1:0] - spt_r;
        end else begin
          step_nxt.trem = tshift_w[SPT_W-1:0];
        end
        if (lge_w) begin
          step_nxt.lrem = lshift_w[SPT_W-1:0] - spt_r;
        end else begin
          step_nxt.lrem = lshift_w[SPT_W-1:0];
        end
      end
      assign stg_nxt[i] = step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NSTG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // Final stage: search sector and action
  stage_t           fin_w;
  logic [SPT_W:0]   wrap_w;
  logic [SPT_W-1:0] ssec_w;
  logic             cyl_eq_w;

  assign fin_w    = stg_r[LAST];
  assign wrap_w   = {1'b0, fin_w.trem} + {1'b0, spt_r} - {1'b0, fin_w.lrem};
  assign ssec_w   = (fin_w.trem >= fin_w.lrem) ? fin_w.trem - fin_w.lrem
                                               : wrap_w[SPT_W-1:0];
  assign cyl_eq_w = fin_w.cyl == CYLX_W'(fin_w.cur_cyl);

  always_comb begin
    res_nxt = '0;
    if (!fin_w.rej) begin
      res_nxt.cyl  = fin_w.cyl[CYL_IN_W-1:0];
      res_nxt.trk  = fin_w.tqd;
      res_nxt.sec  = fin_w.trem;
      res_nxt.ssec = ssec_w;
      priority if (fin_w.skip || !fin_w.rdy) begin
        res_nxt.action = ACT_DIRECT;
      end else if (cyl_eq_w) begin
        res_nxt.action = (seek_only_r || fin_w.rot_ok) ? ACT_DIRECT : ACT_SEARCH;
      end else begin
        res_nxt.load   = 1'b1;
        res_nxt.action = seek_only_r ? ACT_SEEK : ACT_SEARCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_res_r};

`ifndef SYNTH
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && ce |=> out_valid_r)
    else $error("valid word in the last stage did not reach the output");

  a_cyl_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QD_W] && !stg_r[QD_W].rej |-> stg_r[QD_W].prem < spc_r)
    else $error("cylinder divider remainder not below sectors per cylinder");

  a_trk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && !stg_r[LAST].rej |->
      (stg_r[LAST].trem < spt_r) && (stg_r[LAST].lrem < spt_r))
    else $error("track or lead remainder not below sectors per track");

  a_seek_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.load && seek_only_r |-> out_res_r.action == ACT_SEEK)
    else $error("cylinder load in seek-only mode without a seek");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request word not captured in the first stage");
`endif

endmodule
